FILE: rtl/irpt_pkg.sv
// ----------------------------------------------------------------------------
// irpt_pkg
// Shared types and constants for the IR pulse train player.
// ----------------------------------------------------------------------------
package irpt_pkg;

  // Store geometry and duration width.
  localparam int MAX_PULSES    = 32;
  localparam int DURATION_BITS = 8;
  localparam int ADDR_W        = $clog2(MAX_PULSES);
  localparam int POS_W         = $clog2(MAX_PULSES + 1);

  // Fixed widths of the word fields.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 5;
  localparam int DUR_W   = 8;
  localparam int COUNT_W = 6;

  // Command codes; the fourth code is ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // Write port of the duration store.
  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic [DURATION_BITS-1:0] data;
  } store_wr_t;

endpackage

FILE: rtl/irpt_dur_store.sv
// ----------------------------------------------------------------------------
// irpt_dur_store
// Register file of pulse durations, one write port and one registered read port.
// ----------------------------------------------------------------------------
module irpt_dur_store (
  input  logic                              clk,
  input  irpt_pkg::store_wr_t               wr,
  input  logic [irpt_pkg::ADDR_W-1:0]       rd_addr,
  output logic [irpt_pkg::DURATION_BITS-1:0] rd_data
);
  import irpt_pkg::*;

  logic [DURATION_BITS-1:0] entries [MAX_PULSES];

  // Entries hold no reset value; they are filled by write words.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.addr] <= wr.data;
    end
  end

  // The read is registered every cycle; the caller aims the address at the
  // entry that the next word in the input register will need.
  always_ff @(posedge clk) begin
    rd_data <= entries[rd_addr];
  end

endmodule

FILE: rtl/ir_pulse_train_player.sv
// ----------------------------------------------------------------------------
// ir_pulse_train_player
// Plays a stored list of pulse durations as an IR on/off waveform.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the result register is not
// stalled, and returns one result word for each: the word is captured in an
// input register, then the state update and the result are produced together
// in one pass that also writes the result register. That single pass through
// the countdown and the 32-entry duration register file sets the rate; the
// registered read is aimed each cycle at the play position that the next word
// will see. Writes land only while idle, so a train never needs an entry in
// the cycle right after it was written. Write and start words are ignored
// while a train is playing; tick words advance playback, and ir_on and
// busy_res report the state after each word.
module ir_pulse_train_player (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irpt_pkg::CMD_W-1:0]    cmd,
  input  logic [irpt_pkg::INDEX_W-1:0]  entry_index,
  input  logic [irpt_pkg::DUR_W-1:0]    duration_ms,
  input  logic [irpt_pkg::COUNT_W-1:0]  pulse_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ir_on,
  output logic                          busy_res
);
  import irpt_pkg::*;

  // Input register.
  logic               s1_valid;
  logic [CMD_W-1:0]   s1_cmd;
  logic [INDEX_W-1:0] s1_index;
  logic [DUR_W-1:0]   s1_dur;
  logic [COUNT_W-1:0] s1_count;

  // Playback state.
  logic                     playing;
  logic [DURATION_BITS-1:0] countdown;
  logic [POS_W-1:0]         play_position;
  logic [POS_W-1:0]         entries_in_use;
  logic                     emitter_drive;

  logic                     playing_next;
  logic [DURATION_BITS-1:0] countdown_next;
  logic [POS_W-1:0]         play_position_next;
  logic [POS_W-1:0]         entries_in_use_next;
  logic                     emitter_drive_next;

  logic                     advance;
  store_wr_t                store_wr;
  logic [ADDR_W-1:0]        store_rd_addr;
  logic [DURATION_BITS-1:0] store_rd;

  // The input word moves on when the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd   <= cmd;
      s1_index <= entry_index;
      s1_dur   <= duration_ms;
      s1_count <= pulse_count;
    end
  end

  // Duration store, written only while idle.
  always_comb begin
    store_wr.en   = advance && (cmd_t'(s1_cmd) == CMD_WRITE) && !playing &&
                    (32'(s1_index) < MAX_PULSES);
    store_wr.addr = ADDR_W'(s1_index);
    store_wr.data = DURATION_BITS'(s1_dur);
  end

  // Read the position that holds after this edge.
  assign store_rd_addr = advance ? play_position_next[ADDR_W-1:0] :
                                   play_position[ADDR_W-1:0];

  irpt_dur_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd)
  );

  // Next state for the word in the input register.
  always_comb begin
    playing_next        = playing;
    countdown_next      = countdown;
    play_position_next  = play_position;
    entries_in_use_next = entries_in_use;
    emitter_drive_next  = emitter_drive;
    case (cmd_t'(s1_cmd))
      CMD_TICK: begin
        if (playing) begin
          if (countdown == '0) begin
            if (play_position < entries_in_use) begin
              emitter_drive_next = ~play_position[0];
              countdown_next     = store_rd;
              play_position_next = play_position + POS_W'(1);
            end else begin
              emitter_drive_next = 1'b0;
              playing_next       = 1'b0;
              play_position_next = '0;
            end
          end
          if (countdown_next != '0) begin
            countdown_next = countdown_next - DURATION_BITS'(1);
          end
        end
      end
      CMD_START: begin
        if (!playing) begin
          play_position_next  = '0;
          entries_in_use_next = (32'(s1_count) > MAX_PULSES) ?
                                POS_W'(MAX_PULSES) : POS_W'(s1_count);
          playing_next        = 1'b1;
        end
      end
      default: begin
        // Write words touch only the store; the unused code does nothing.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      countdown      <= '0;
      play_position  <= '0;
      entries_in_use <= '0;
      emitter_drive  <= 1'b0;
    end else if (advance) begin
      playing        <= playing_next;
      countdown      <= countdown_next;
      play_position  <= play_position_next;
      entries_in_use <= entries_in_use_next;
      emitter_drive  <= emitter_drive_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ir_on    <= emitter_drive_next;
      busy_res <= playing_next;
    end
  end

`ifndef SYNTHESIS
  // An idle block always has its countdown run out.
  a_idle_countdown: assert property (@(posedge clk) disable iff (rst)
    !playing |-> countdown == '0)
    else $error("countdown nonzero while idle");

  // Playback never runs past the number of entries in use.
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    play_position <= entries_in_use && 32'(entries_in_use) <= MAX_PULSES)
    else $error("play position beyond entries in use");

  // The emitter is driven only while a train plays.
  a_on_implies_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && ir_on |-> busy_res)
    else $error("emitter on while idle");

  // A word that moves on always reaches the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");
`endif

endmodule

FILE: tb/irpt_waveform_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpt_waveform_checker
// Watches both word channels of the IR pulse train player, predicts the
// emitter drive and busy flag for every accepted input word, and compares
// them with the result words in order.
// ----------------------------------------------------------------------------
module irpt_waveform_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [irpt_pkg::CMD_W-1:0]    cmd,
  input  logic [irpt_pkg::INDEX_W-1:0]  entry_index,
  input  logic [irpt_pkg::DUR_W-1:0]    duration_ms,
  input  logic [irpt_pkg::COUNT_W-1:0]  pulse_count,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          ir_on,
  input  logic                          busy_res,
  output int                            fail_count,
  output int                            pending_words,
  output int                            compared_words,
  output int                            trains_started
);
  import irpt_pkg::*;

  typedef struct packed {
    logic ir_on;
    logic busy;
  } emitter_state_t;

  // Shadow of the player state.
  logic                     playing_m;
  logic [DURATION_BITS-1:0] countdown_m;
  logic [POS_W-1:0]         position_m;
  logic [POS_W-1:0]         span_m;
  logic [DURATION_BITS-1:0] store_m [MAX_PULSES];
  logic                     drive_m;

  // Predicted result words, oldest first.
  emitter_state_t expected_drive_q [$];

  // Applies one input word to the shadow state and returns the result word.
  function automatic emitter_state_t step_player(
    input logic [CMD_W-1:0]   c,
    input logic [INDEX_W-1:0] idx,
    input logic [DUR_W-1:0]   dur,
    input logic [COUNT_W-1:0] cnt
  );
    emitter_state_t res;
    case (c)
      CMD_TICK: begin
        if (playing_m) begin
          // A spent countdown loads the next entry or ends the train.
          if (countdown_m == '0) begin
            if (position_m < span_m) begin
              drive_m     = ~position_m[0];
              countdown_m = store_m[position_m[ADDR_W-1:0]];
              position_m  = position_m + 1'b1;
            end else begin
              drive_m    = 1'b0;
              playing_m  = 1'b0;
              position_m = '0;
            end
          end
          if (countdown_m != '0) countdown_m = countdown_m - 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!playing_m) store_m[idx] = dur;
      end
      CMD_START: begin
        if (!playing_m) begin
          position_m = '0;
          span_m     = (cnt > MAX_PULSES) ? POS_W'(MAX_PULSES) : cnt;
          playing_m  = 1'b1;
          trains_started++;
        end
      end
      default: ;
    endcase
    res.ir_on = drive_m;
    res.busy  = playing_m;
    return res;
  endfunction

  // Predict on every accepted input word, compare on every accepted result.
  always @(posedge clk) begin : watch_words
    emitter_state_t want;
    if (rst) begin
      playing_m      = 1'b0;
      countdown_m    = '0;
      position_m     = '0;
      span_m         = '0;
      drive_m        = 1'b0;
      fail_count     = 0;
      compared_words = 0;
      trains_started = 0;
      expected_drive_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_drive_q.push_back(step_player(cmd, entry_index, duration_ms, pulse_count));
      end
      if (out_valid && !out_stall) begin
        if (expected_drive_q.size() == 0) begin
          $error("Result word arrived with no prediction pending.");
          fail_count++;
        end else begin
          want = expected_drive_q.pop_front();
          compared_words++;
          if (ir_on !== want.ir_on) begin
            $error("ir_on mismatch: expected %0b, actual %0b", want.ir_on, ir_on);
            fail_count++;
          end
          if (busy_res !== want.busy) begin
            $error("busy_res mismatch: expected %0b, actual %0b", want.busy, busy_res);
            fail_count++;
          end
        end
      end
    end
    pending_words <= expected_drive_q.size();
  end

endmodule

FILE: tb/tb_ir_pulse_train_player.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_train_player
// Drives the IR pulse train player with directed and random word sequences
// (store writes, starts, millisecond ticks and stray words) under varying
// input gaps and output stalls; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_ir_pulse_train_player;
  import irpt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WORD_TARGET  = 1950;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd         = '0;
  logic [INDEX_W-1:0]  entry_index = '0;
  logic [DUR_W-1:0]    duration_ms = '0;
  logic [COUNT_W-1:0]  pulse_count = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic                ir_on;
  logic                busy_res;

  int fail_count;
  int pending_words;
  int compared_words;
  int trains_started;

  // Stimulus bookkeeping.
  int words_sent = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;
  int planned_duration [MAX_PULSES];

  ir_pulse_train_player dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .entry_index (entry_index),
    .duration_ms (duration_ms),
    .pulse_count (pulse_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ir_on       (ir_on),
    .busy_res    (busy_res)
  );

  irpt_waveform_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .duration_ms    (duration_ms),
    .pulse_count    (pulse_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ir_on          (ir_on),
    .busy_res       (busy_res),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .compared_words (compared_words),
    .trains_started (trains_started)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one word, with random idle cycles ahead of it, and waits for
  // acceptance. Words that only probe ignored paths are not counted.
  task automatic send_word(
    input logic [CMD_W-1:0]   c,
    input logic [INDEX_W-1:0] idx,
    input logic [DUR_W-1:0]   dur,
    input logic [COUNT_W-1:0] cnt,
    input bit                 counted
  );
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    duration_ms <= dur;
    pulse_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) words_sent++;
    if (words_sent == HOLD_AT_WORD) hold_req = 1'b1;
    // Idling phases follow the progress of the run.
    case (words_sent * 5 / WORD_TARGET)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 85; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 85; end
      3:       begin idle_pct = 14; stall_pct = 14; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin : stimulus
    int n_writes;
    int idx;
    int dur;
    int cnt;
    int ticks;
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick, stray code, writes at the store ends, zero count,
    // a short train with a zero-length entry, and words ignored while busy.
    send_word(CMD_TICK,   '1, '1, '1, 1'b1);
    send_word(CMD_UNUSED, '0, '0, '0, 1'b0);
    send_word(CMD_WRITE,  INDEX_W'(0),  DUR_W'(0),   '0, 1'b1);
    send_word(CMD_WRITE,  INDEX_W'(1),  DUR_W'(2),   '1, 1'b1);
    send_word(CMD_WRITE,  INDEX_W'(31), DUR_W'(255), '0, 1'b1);
    send_word(CMD_START,  '0, '0, COUNT_W'(0), 1'b1);
    send_word(CMD_TICK,   '0, '0, '0, 1'b1);
    send_word(CMD_START,  '1, '1, COUNT_W'(2), 1'b1);
    send_word(CMD_WRITE,  INDEX_W'(2), DUR_W'(1), '0, 1'b0);
    send_word(CMD_START,  '0, '0, COUNT_W'(63), 1'b0);
    send_word(CMD_UNUSED, '1, '1, '1, 1'b0);
    repeat (4) send_word(CMD_TICK, '0, '0, '0, 1'b1);
    send_word(CMD_TICK,   '0, '0, '0, 1'b1);

    // Fill the whole store so that no train can reach an unwritten entry.
    for (int i = 0; i < MAX_PULSES; i++) begin
      dur = $urandom_range(0, 6);
      send_word(CMD_WRITE, INDEX_W'(i), DUR_W'(dur), COUNT_W'($urandom), 1'b1);
      planned_duration[i] = dur;
    end

    // Random trains: a few writes, a start, then enough ticks to finish,
    // now and then cut short, with stray words sprinkled in.
    while (words_sent < WORD_TARGET) begin
      n_writes = $urandom_range(0, 4);
      repeat (n_writes) begin
        idx = $urandom_range(0, MAX_PULSES - 1);
        r   = $urandom_range(99);
        if (r < 3)       dur = $urandom_range(200, 255);
        else if (r < 12) dur = $urandom_range(7, 40);
        else             dur = $urandom_range(0, 6);
        send_word(CMD_WRITE, INDEX_W'(idx), DUR_W'(dur), COUNT_W'($urandom), 1'b1);
        planned_duration[idx] = dur;
      end
      r = $urandom_range(99);
      if (r < 70)      cnt = $urandom_range(0, 8);
      else if (r < 94) cnt = $urandom_range(9, 31);
      else             cnt = $urandom_range(32, 63);
      send_word(CMD_START, INDEX_W'($urandom), DUR_W'($urandom), COUNT_W'(cnt), 1'b1);
      ticks = 1;
      for (int i = 0; i < cnt && i < MAX_PULSES; i++) begin
        ticks += (planned_duration[i] == 0) ? 1 : planned_duration[i];
      end
      if ($urandom_range(9) == 0) ticks = $urandom_range(0, ticks);
      ticks += $urandom_range(0, 2);
      repeat (ticks) begin
        if ($urandom_range(99) < 5) begin
          r = $urandom_range(2);
          send_word((r == 0) ? CMD_WRITE : (r == 1) ? CMD_START : CMD_UNUSED,
                    INDEX_W'($urandom), DUR_W'($urandom), COUNT_W'($urandom), 1'b0);
        end
        send_word(CMD_TICK, INDEX_W'($urandom), DUR_W'($urandom),
                  COUNT_W'($urandom), 1'b1);
      end
    end

    // Drain: stop offering, release the output, wait for every result.
    in_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words and started %0d pulse trains; %0d results compared.",
             words_sent, trains_started, compared_words);
    $display("Run went through free flow, sparse input, heavy output stall, "
             , "mixed idling and one long output hold.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results outstanding.", pending_words);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
